/* rtl/b2ss_pkg.sv */
// ----------------------------------------------------------------------------
// b2ss_pkg
// Shared types, constants and functions for the binary to seven-segment block.
// ----------------------------------------------------------------------------
package b2ss_pkg;

	localparam int VALUE_W         = 27;
	localparam int IN_DATA_W       = 32;
	localparam int SEG_W           = 8;
	localparam int POSITIONS       = 8;
	localparam int OUT_DATA_W      = POSITIONS * SEG_W;
	localparam int BCD_W           = 4;
	localparam int CNT_W           = $clog2(VALUE_W);
	localparam int DIGIT_COUNT_DEF = 8;

	localparam logic [SEG_W-1:0] SEG_BLANK = 8'hFF;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic clr;
		logic shift;
	} cell_ctrl_t;

	function automatic logic [VALUE_W-1:0] max_value(input int digits);
		logic [VALUE_W:0] m;
		m = (VALUE_W+1)'(1);
		for (int k = 0; k < digits; k++) begin
			m = (VALUE_W+1)'(m * 10);
		end
		return VALUE_W'(m - 1'b1);
	endfunction

	function automatic logic [SEG_W-1:0] seg_code(input logic [BCD_W-1:0] d);
		logic [SEG_W-1:0] s;
		unique case (d)
			4'd0:    s = 8'hC0;
			4'd1:    s = 8'hF9;
			4'd2:    s = 8'hA4;
			4'd3:    s = 8'hB0;
			4'd4:    s = 8'h99;
			4'd5:    s = 8'h92;
			4'd6:    s = 8'h82;
			4'd7:    s = 8'hF8;
			4'd8:    s = 8'h80;
			4'd9:    s = 8'h90;
			default: s = SEG_BLANK;
		endcase
		return s;
	endfunction

endpackage

/* rtl/b2ss_cell.sv */
// ----------------------------------------------------------------------------
// b2ss_cell
// One BCD digit of the shift-and-add-3 chain: adjust, then shift left by one.
// ----------------------------------------------------------------------------
module b2ss_cell (
	input  logic                        clk,
	input  b2ss_pkg::cell_ctrl_t        ctrl,
	input  logic                        shift_in,
	output logic                        shift_out,
	output logic [b2ss_pkg::BCD_W-1:0]  digit
);
	import b2ss_pkg::*;

	logic [BCD_W-1:0] digit_q;
	logic [BCD_W-1:0] adj;

	always_comb begin
		adj = (digit_q >= BCD_W'(5)) ? BCD_W'(digit_q + BCD_W'(3)) : digit_q;
	end

	always_ff @(posedge clk) begin
		if (ctrl.clr) begin
			digit_q <= '0;
		end else if (ctrl.shift) begin
			digit_q <= {adj[BCD_W-2:0], shift_in};
		end
	end

	assign shift_out = adj[BCD_W-1];
	assign digit     = digit_q;

endmodule

/* rtl/binary_to_seven_segment_top.sv */
// Each number is shifted in 27 steps through the digit cell chain, then loaded out.
// A new number is taken only once the last one is through the chain, and it is taken
// while a finished result waits in the output register.
// Reset: arst_n clears the state machine and the output valid flag asynchronously;
// digit and data registers are not reset.
// ----------------------------------------------------------------------------
// binary_to_seven_segment_top
// Binary to eight-digit active-low seven-segment encoder with leading blanking.
// ----------------------------------------------------------------------------
module binary_to_seven_segment_top #(
	parameter int DIGIT_COUNT = b2ss_pkg::DIGIT_COUNT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [b2ss_pkg::IN_DATA_W-1:0]    s_tdata,  // value[26:0], zero fill
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [b2ss_pkg::OUT_DATA_W-1:0]   m_tdata   // seg_digit_0 .. seg_digit_7
);
	import b2ss_pkg::*;

	localparam logic [VALUE_W-1:0] MAX_VAL = max_value(DIGIT_COUNT);

	state_t            state_q, state_d;
	logic [VALUE_W-1:0] bin_q;
	logic [VALUE_W-1:0] in_val;
	logic [CNT_W-1:0]   cnt_q;
	cell_ctrl_t         ctrl;
	logic               load_out;
	logic               accept;
	logic               m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic [OUT_DATA_W-1:0] seg_all;

	logic [DIGIT_COUNT:0]   carry;
	logic [BCD_W-1:0]       dig    [DIGIT_COUNT];
	logic [BCD_W-1:0]       dig_pad[POSITIONS];
	logic [POSITIONS:0]     nz_above;

	assign in_val = s_tdata[VALUE_W-1:0];
	assign accept = s_tvalid && s_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (s_tvalid) state_d = ST_CONV;
			ST_CONV: if (cnt_q == '0) state_d = ST_DONE;
			ST_DONE: if (!m_tvalid_q || m_tready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready   = 1'b0;
		ctrl.clr   = 1'b0;
		ctrl.shift = 1'b0;
		load_out   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				ctrl.clr = s_tvalid;
			end
			ST_CONV: ctrl.shift = 1'b1;
			ST_DONE: load_out = !m_tvalid_q || m_tready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bin_q <= (in_val > MAX_VAL) ? MAX_VAL : in_val;
			cnt_q <= CNT_W'(VALUE_W - 1);
		end else if (ctrl.shift) begin
			bin_q <= {bin_q[VALUE_W-2:0], 1'b0};
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign carry[0] = bin_q[VALUE_W-1];

	for (genvar g = 0; g < DIGIT_COUNT; g++) begin : g_cell
		b2ss_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.shift_in  (carry[g]),
			.shift_out (carry[g+1]),
			.digit     (dig[g])
		);
	end

	for (genvar g = 0; g < POSITIONS; g++) begin : g_pad
		if (g < DIGIT_COUNT) begin : g_used
			assign dig_pad[g] = dig[g];
		end else begin : g_unused
			assign dig_pad[g] = '0;
		end
	end

	always_comb begin
		nz_above[POSITIONS] = 1'b0;
		for (int k = POSITIONS - 1; k >= 0; k--) begin
			nz_above[k] = nz_above[k+1] || (dig_pad[k] != '0);
		end
		for (int k = 0; k < POSITIONS; k++) begin
			if (k < DIGIT_COUNT && (k == 0 || nz_above[k])) begin
				seg_all[k*SEG_W +: SEG_W] = seg_code(dig_pad[k]);
			end else begin
				seg_all[k*SEG_W +: SEG_W] = SEG_BLANK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tdata_q <= seg_all;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef NO_ASSERTIONS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_CONV) && (cnt_q == CNT_W'(VALUE_W - 1)))
		else $error("accepted beat did not start a conversion");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CONV) |-> !carry[DIGIT_COUNT])
		else $error("digit chain overflow");

	a_result_loads: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> m_tvalid && (state_q == ST_IDLE))
		else $error("finished result not presented");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !load_out |=> !m_tvalid)
		else $error("output beat repeated");
`endif

endmodule

/* test/segment_code_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// segment_code_checker
// Watches both stream channels of the binary to seven-segment block. It turns
// every accepted number into the eight expected segment codes and compares
// each result beat against them, digit by digit, in arrival order.
// ----------------------------------------------------------------------------
module segment_code_checker #(
	parameter int DIGIT_COUNT = b2ss_pkg::DIGIT_COUNT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	input  logic                              s_tready,
	input  logic [b2ss_pkg::IN_DATA_W-1:0]    s_tdata,  // value[26:0], zero fill
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic [b2ss_pkg::OUT_DATA_W-1:0]   m_tdata,  // seg_digit_0 .. seg_digit_7
	output int                                mismatch_count,
	output int                                codes_pending
);
	import b2ss_pkg::*;

	typedef logic [POSITIONS-1:0][SEG_W-1:0] seg_row_t;

	localparam logic [9:0][SEG_W-1:0] DIGIT_SEGMENTS = {
		8'h90, 8'h80, 8'hF8, 8'h82, 8'h92, 8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0
	};

	seg_row_t expected_codes[$];

	function automatic seg_row_t encode_segments(input logic [VALUE_W-1:0] value);
		seg_row_t codes;
		int unsigned digits;
		int unsigned ceiling;
		int unsigned v;
		digits = (DIGIT_COUNT < 4) ? 4 : (DIGIT_COUNT > POSITIONS) ? POSITIONS : DIGIT_COUNT;
		ceiling = 1;
		for (int k = 0; k < digits; k++) begin
			ceiling = ceiling * 10;
		end
		ceiling = ceiling - 1;
		v = 32'(value);
		if (v > ceiling) begin
			v = ceiling;
		end
		for (int k = 0; k < POSITIONS; k++) begin
			codes[k] = SEG_BLANK;
		end
		if (v == 0) begin
			codes[0] = DIGIT_SEGMENTS[0];
		end
		for (int k = 0; k < digits && v != 0; k++) begin
			codes[k] = DIGIT_SEGMENTS[4'(v % 10)];
			v = v / 10;
		end
		return codes;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		seg_row_t want;
		logic [SEG_W-1:0] got;
		if (!arst_n) begin
			expected_codes.delete();
			mismatch_count = 0;
			codes_pending = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_codes.size() == 0) begin
					$display("%0t: result beat %h with no number pending", $time, m_tdata);
					mismatch_count++;
				end else begin
					want = expected_codes.pop_front();
					for (int k = 0; k < POSITIONS; k++) begin
						got = m_tdata[k*SEG_W +: SEG_W];
						if (got !== want[k]) begin
							$display("%0t: seg_digit_%0d expected %h, got %h",
								$time, k, want[k], got);
							mismatch_count++;
						end
					end
				end
			end
			if (s_tvalid && s_tready) begin
				expected_codes.push_back(encode_segments(s_tdata[VALUE_W-1:0]));
			end
			codes_pending = expected_codes.size();
		end
	end

endmodule

/* test/binary_to_seven_segment_top_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_to_seven_segment_top_test
// Drives numbers into the seven-segment encoder in random bursts, first corner
// values, then random values spread over every digit count and over the
// saturation range. The result side stalls on its own patterns, with long
// hold-offs that back the block up. Checking is done by segment_code_checker.
// ----------------------------------------------------------------------------
module binary_to_seven_segment_top_test;
	import b2ss_pkg::*;

	localparam int CLK_PERIOD   = 20;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int DRAIN_CYCLES = 80;
	localparam int RANDOM_ITEMS = 1300;
	localparam int CORNER_COUNT = 25;

	localparam logic [CORNER_COUNT-1:0][VALUE_W-1:0] CORNER_VALUES = {
		27'd0,        27'd1,        27'd9,        27'd10,       27'd99,
		27'd100,      27'd101,      27'd999,      27'd1000,     27'd9999,
		27'd10000,    27'd100000,   27'd1000000,  27'd1234567,  27'd10000000,
		27'd12345678, 27'd87654321, 27'd90000000, 27'd99999998, 27'd99999999,
		27'd100000000, 27'd67108864, 27'h5555555, 27'h2AAAAAA,  27'h7FFFFFF
	};

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_DATA_W-1:0]   s_tdata;   // value[26:0], zero fill
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_DATA_W-1:0]  m_tdata;   // seg_digit_0 .. seg_digit_7
	int                     mismatch_count;
	int                     codes_pending;
	int                     cycle_count;

	binary_to_seven_segment_top #(
		.DIGIT_COUNT(DIGIT_COUNT_DEF)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	segment_code_checker #(
		.DIGIT_COUNT(DIGIT_COUNT_DEF)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.mismatch_count (mismatch_count),
		.codes_pending  (codes_pending)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD/2) clk = ~clk;
	end

	initial begin
		cycle_count = 0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		logic [VALUE_W-1:0] numbers[$];
		int unsigned digit_lo;
		int unsigned digit_hi;
		int unsigned n;
		int burst_len;
		int gap;
		int idx;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		for (int k = CORNER_COUNT - 1; k >= 0; k--) begin
			numbers.push_back(CORNER_VALUES[k]);
		end
		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			case ($urandom_range(0, 5))
				0: numbers.push_back(VALUE_W'($urandom));
				1: numbers.push_back(VALUE_W'($urandom_range(100000049, 99999949)));
				2: numbers.push_back(VALUE_W'($urandom_range(200, 0)));
				default: begin
					n = $urandom_range(1, 8);
					digit_lo = 1;
					for (int d = 1; d < n; d++) begin
						digit_lo = digit_lo * 10;
					end
					digit_hi = digit_lo * 10 - 1;
					if (n == 1) begin
						digit_lo = 0;
					end
					numbers.push_back(VALUE_W'($urandom_range(digit_hi, digit_lo)));
				end
			endcase
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		idx = 0;
		while (idx < numbers.size()) begin
			burst_len = $urandom_range(1, 24);
			for (int b = 0; b < burst_len && idx < numbers.size(); b++) begin
				@(negedge clk);
				s_tvalid <= 1'b1;
				s_tdata  <= {{(IN_DATA_W-VALUE_W){1'b0}}, numbers[idx]};
				do @(posedge clk); while (!s_tready);
				idx++;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
			if (gap > 0) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				s_tdata  <= $urandom;
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (codes_pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		logic [7:0] ready_pattern;
		int phase_len;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		// hold off so the block backs up while numbers keep coming
		repeat (150) @(negedge clk);
		forever begin
			phase_len = $urandom_range(20, 200);
			ready_pattern = 8'($urandom) | 8'h01;
			case ($urandom_range(0, 7))
				0, 1: begin
					repeat (phase_len) begin
						@(negedge clk);
						m_tready <= 1'b1;
					end
				end
				2, 3: begin
					repeat (phase_len) begin
						@(negedge clk);
						m_tready <= 1'($urandom_range(0, 1));
					end
				end
				4, 5: begin
					repeat (phase_len) begin
						@(negedge clk);
						m_tready <= ready_pattern[0];
						ready_pattern = {ready_pattern[0], ready_pattern[7:1]};
					end
				end
				6: begin
					repeat (phase_len) begin
						@(negedge clk);
						m_tready <= ($urandom_range(0, 3) == 0);
					end
				end
				default: begin
					@(negedge clk);
					m_tready <= 1'b0;
					repeat ($urandom_range(100, 300)) @(negedge clk);
				end
			endcase
		end
	end

endmodule
